@@ rtl/core/nvsh_pkg.sv @@
// ----------------------------------------------------------------------------
// nvsh_pkg
// Types, codes and constants shared by the nearest viewpoint selector.
// ----------------------------------------------------------------------------
`default_nettype none

package nvsh_pkg;

  localparam int COORD_W    = 24;
  localparam int TIME_W     = 16;
  localparam int GAIN_W     = 50;
  localparam int VIEW_IDX_W = 4;
  localparam int CMD_W      = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int MAG_W      = COORD_W + 1;
  localparam int SQ_W       = 2 * MAG_W;

  localparam logic [GAIN_W-1:0] MIN_GAIN_SQ_RST = 50'd589824;
  localparam logic [TIME_W-1:0] HOLD_TIME_RST   = 16'd1638;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_GAIN_SQ = 1'b0,
    REG_HOLD_TIME   = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DECIDE,
    S_FETCH,
    S_RESULT,
    S_EMPTY
  } state_e;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  // Magnitude of a - b, exact in MAG_W bits.
  function automatic logic [MAG_W-1:0] abs_diff(input coord_t a, input coord_t b);
    logic signed [MAG_W-1:0] d;
    d = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
    return d[MAG_W-1] ? MAG_W'(-d) : MAG_W'(d);
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/nearest_view_select_hysteresis.sv @@
// Load and clear take effect at the transfer.
// A tick with N stored points reads the table one entry per cycle through a
// 4-stage distance unit, then decides and fetches the chosen point; no new
// item is taken until its result has been loaded into the output register.
// A tick on an empty table shows an all-zero result.
// Reset clears count, choice and cooldown and loads the register defaults.
// ----------------------------------------------------------------------------
// nearest_view_select_hysteresis
// Viewpoint table with nearest-point search and cooldown-gated switching.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_view_select_hysteresis #(
  parameter int MAX_VIEWS = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [nvsh_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [nvsh_pkg::GAIN_W-1:0]         cfg_data_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic [nvsh_pkg::CMD_W-1:0]          cmd_i,
  input  wire logic signed [nvsh_pkg::COORD_W-1:0] pos_x_i,
  input  wire logic signed [nvsh_pkg::COORD_W-1:0] pos_y_i,
  input  wire logic signed [nvsh_pkg::COORD_W-1:0] pos_z_i,
  input  wire logic [nvsh_pkg::TIME_W-1:0]         step_time_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic                                     have_view_o,
  output logic [nvsh_pkg::VIEW_IDX_W-1:0]          view_index_o,
  output logic signed [nvsh_pkg::COORD_W-1:0]      view_x_o,
  output logic signed [nvsh_pkg::COORD_W-1:0]      view_y_o,
  output logic signed [nvsh_pkg::COORD_W-1:0]      view_z_o,
  output logic                                     switched_o
);

  import nvsh_pkg::*;

  localparam int IDX_W = (MAX_VIEWS > 1) ? $clog2(MAX_VIEWS) : 1;
  localparam int CNT_W = $clog2(MAX_VIEWS + 1);

  // Configuration
  logic [GAIN_W-1:0] min_gain_q;
  logic [TIME_W-1:0] hold_time_q;

  // Control state
  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q;
  logic [IDX_W-1:0]  chosen_q;
  logic              chosen_valid_q;
  logic [TIME_W-1:0] cooldown_q;
  logic [CNT_W-1:0]  rd_idx_q;

  // Tick operands
  coord_t            tgt_x_q, tgt_y_q, tgt_z_q;
  logic [TIME_W-1:0] dt_q;

  // Table
  point_t            mem_q [MAX_VIEWS];
  point_t            rd_data_q;
  logic [IDX_W-1:0]  rd_addr;

  // Distance unit pipeline
  logic              s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q;
  logic [IDX_W-1:0]  s1_idx_q, s2_idx_q, s3_idx_q, s4_idx_q;
  logic [MAG_W-1:0]  mag_x_q, mag_y_q, mag_z_q;
  logic [SQ_W-1:0]   sq_x_q, sq_y_q, sq_z_q;
  logic [SQ_W-1:0]   d2_q;
  logic [SQ_W-1:0]   best_d2_q, cur_d2_q;
  logic [IDX_W-1:0]  best_idx_q;
  logic              switched_q;

  // Sequencer outputs
  logic              accept;
  logic              scan_issue;
  logic              pipe_busy;
  logic              out_free;
  logic              load_result;
  logic              load_empty;
  logic              decide_en;
  cmd_e              cmd;

  // Decision
  logic [TIME_W-1:0] cd_next;
  logic              adopt;
  logic              better;
  logic              do_switch;

  assign cmd       = cmd_e'(cmd_i);
  assign accept    = in_valid_i && in_ready_o;
  assign pipe_busy = s1_vld_q || s2_vld_q || s3_vld_q || s4_vld_q;
  assign out_free  = !out_valid_o || out_ready_i;
  assign rd_addr   = (state_q == S_SCAN) ? rd_idx_q[IDX_W-1:0] : chosen_q;

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && cmd == CMD_TICK) begin
          state_d = (count_q == '0) ? S_EMPTY : S_SCAN;
        end
      end
      S_SCAN: begin
        if (rd_idx_q + CNT_W'(1) == count_q) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!pipe_busy) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: state_d = S_FETCH;
      S_FETCH:  state_d = S_RESULT;
      S_RESULT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_EMPTY: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // ------------------------------------------------------------------ outputs
  always_comb begin
    in_ready_o  = 1'b0;
    scan_issue  = 1'b0;
    decide_en   = 1'b0;
    load_result = 1'b0;
    load_empty  = 1'b0;
    unique case (state_q)
      S_IDLE:   in_ready_o  = 1'b1;
      S_SCAN:   scan_issue  = 1'b1;
      S_DECIDE: decide_en   = 1'b1;
      S_RESULT: load_result = out_free;
      S_EMPTY:  load_empty  = out_free;
      default: begin
      end
    endcase
  end

  // ----------------------------------------------------------- configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_gain_q  <= MIN_GAIN_SQ_RST;
      hold_time_q <= HOLD_TIME_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_MIN_GAIN_SQ: min_gain_q  <= cfg_data_i;
        REG_HOLD_TIME:   hold_time_q <= cfg_data_i[TIME_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // ------------------------------------------------------------------- table
  always_ff @(posedge clk_i) begin
    if (accept && cmd == CMD_LOAD && count_q < CNT_W'(MAX_VIEWS)) begin
      mem_q[count_q[IDX_W-1:0]] <= '{x: pos_x_i, y: pos_y_i, z: pos_z_i};
    end
    rd_data_q <= mem_q[rd_addr];
  end

  // ------------------------------------------------------------ decide logic
  always_comb begin
    cd_next   = (cooldown_q > dt_q) ? cooldown_q - dt_q : '0;
    adopt     = !chosen_valid_q || (CNT_W'(chosen_q) >= count_q);
    better    = ({1'b0, best_d2_q} + {1'b0, min_gain_q}) < {1'b0, cur_d2_q};
    do_switch = adopt || (cd_next == '0 && best_idx_q != chosen_q && better);
  end

  // ----------------------------------------------------------- control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      count_q        <= '0;
      chosen_q       <= '0;
      chosen_valid_q <= 1'b0;
      cooldown_q     <= '0;
      rd_idx_q       <= '0;
      s1_vld_q       <= 1'b0;
      s2_vld_q       <= 1'b0;
      s3_vld_q       <= 1'b0;
      s4_vld_q       <= 1'b0;
      out_valid_o    <= 1'b0;
    end else begin
      state_q  <= state_d;
      s1_vld_q <= scan_issue;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;

      if (accept) begin
        unique case (cmd)
          CMD_LOAD: begin
            if (count_q < CNT_W'(MAX_VIEWS)) begin
              count_q <= count_q + CNT_W'(1);
            end
          end
          CMD_CLEAR: begin
            count_q        <= '0;
            chosen_q       <= '0;
            chosen_valid_q <= 1'b0;
            cooldown_q     <= '0;
          end
          CMD_TICK: rd_idx_q <= '0;
          default: begin
          end
        endcase
      end

      if (scan_issue) begin
        rd_idx_q <= rd_idx_q + CNT_W'(1);
      end

      if (decide_en) begin
        chosen_valid_q <= 1'b1;
        chosen_q       <= do_switch ? best_idx_q : chosen_q;
        cooldown_q     <= do_switch ? hold_time_q : cd_next;
      end

      // drop the result on transfer, refill when a new one is ready
      if (load_result || load_empty) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk_i) begin
    if (accept && cmd == CMD_TICK) begin
      tgt_x_q <= pos_x_i;
      tgt_y_q <= pos_y_i;
      tgt_z_q <= pos_z_i;
      dt_q    <= step_time_i;
    end

    s1_idx_q <= rd_idx_q[IDX_W-1:0];
    s2_idx_q <= s1_idx_q;
    s3_idx_q <= s2_idx_q;
    s4_idx_q <= s3_idx_q;

    mag_x_q <= abs_diff(rd_data_q.x, tgt_x_q);
    mag_y_q <= abs_diff(rd_data_q.y, tgt_y_q);
    mag_z_q <= abs_diff(rd_data_q.z, tgt_z_q);

    sq_x_q <= SQ_W'(mag_x_q) * SQ_W'(mag_x_q);
    sq_y_q <= SQ_W'(mag_y_q) * SQ_W'(mag_y_q);
    sq_z_q <= SQ_W'(mag_z_q) * SQ_W'(mag_z_q);

    // sum stays below 2^50, no carry out
    d2_q <= sq_x_q + sq_y_q + sq_z_q;

    if (s4_vld_q) begin
      // strict compare keeps the lowest index on ties
      if (s4_idx_q == '0 || d2_q < best_d2_q) begin
        best_d2_q  <= d2_q;
        best_idx_q <= s4_idx_q;
      end
      if (s4_idx_q == chosen_q) begin
        cur_d2_q <= d2_q;
      end
    end

    if (decide_en) begin
      switched_q <= do_switch;
    end

    if (load_result) begin
      have_view_o  <= 1'b1;
      view_index_o <= VIEW_IDX_W'(chosen_q);
      view_x_o     <= rd_data_q.x;
      view_y_o     <= rd_data_q.y;
      view_z_o     <= rd_data_q.z;
      switched_o   <= switched_q;
    end else if (load_empty) begin
      have_view_o  <= 1'b0;
      view_index_o <= '0;
      view_x_o     <= '0;
      view_y_o     <= '0;
      view_z_o     <= '0;
      switched_o   <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_chosen_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chosen_valid_q |-> (CNT_W'(chosen_q) < count_q))
    else $error("chosen viewpoint outside the loaded table");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_VIEWS))
    else $error("point count above capacity");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (rd_idx_q < count_q))
    else $error("scan reads past the last loaded point");

  a_decide_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DECIDE) |-> !pipe_busy)
    else $error("decision taken with distances still in flight");

  a_switch_needs_view: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && switched_o) |-> have_view_o)
    else $error("switch reported without a chosen viewpoint");
`endif

endmodule

`default_nettype wire
